// ----- src/number_range_list_parser_unit_assert.svh -----
// Assertion macros for the number range list parser sources.
`ifndef NUMBER_RANGE_LIST_PARSER_UNIT_ASSERT_SVH
`define NUMBER_RANGE_LIST_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define NRLP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define NRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/nrlp_pkg.sv -----
// Types and constants for the number range list parser.
package nrlp_pkg;

   typedef enum logic [1:0] {
      GS_COMMA  = 2'd0,
      GS_HYPHEN = 2'd1,
      GS_NUMBER = 2'd2,
      GS_RANGE  = 2'd3
   } nrlp_gstate_type;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_DIGIT  = 3'd1,
      ERR_COMMA  = 3'd2,
      ERR_CHAR   = 3'd3,
      ERR_RANGE  = 3'd4,
      ERR_DESC   = 3'd5,
      ERR_MANY   = 3'd6
   } nrlp_error_type;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [8:0] MAX_ENTRIES = 9'd255;
   localparam logic [8:0] ACCUM_SAT   = 9'd511;

   typedef struct packed {
      nrlp_gstate_type gstate;
      logic [8:0]      accum;
      logic            in_num;
      logic [7:0]      range_begin;
      logic [7:0]      entries;
      nrlp_error_type  err;
   } nrlp_state_type;

   typedef struct packed {
      logic           span_valid;
      logic [7:0]     span_first;
      logic [7:0]     span_last;
      logic [7:0]     entry_total;
      logic           list_done;
      logic           error_flag;
      nrlp_error_type error_kind;
   } nrlp_result_type;

   localparam nrlp_state_type STATE_RESET = '{
      gstate: GS_COMMA, accum: 9'd0, in_num: 1'b0, range_begin: 8'd0,
      entries: 8'd0, err: ERR_NONE};

endpackage

// ----- src/nrlp_step.sv -----
// One parse step: next parse state and result for one character.
module nrlp_step (
   input  nrlp_pkg::nrlp_state_type  st,
   input  logic [7:0]                char_code,
   input  logic                      is_final,
   input  logic                      is_empty,
   input  logic [7:0]                min_value,
   input  logic [7:0]                max_value,
   output nrlp_pkg::nrlp_state_type  st_next,
   output nrlp_pkg::nrlp_result_type res
);
   import nrlp_pkg::*;

   nrlp_state_type s;
   logic           is_digit;
   logic           active;
   logic           do_finish;
   logic [12:0]    prod;
   logic [8:0]     num;
   logic [7:0]     first;
   logic [7:0]     add;
   logic [8:0]     total;
   logic           sv;
   logic [7:0]     sf;
   logic [7:0]     sl;

   assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign prod = ({4'd0, st.accum} << 3) + ({4'd0, st.accum} << 1)
               + {9'd0, char_code[3:0]};

   always_comb begin
      s = st;
      sv = 1'b0;
      sf = 8'd0;
      sl = 8'd0;
      num = 9'd0;
      first = 8'd0;
      add = 8'd0;
      total = 9'd0;

      // A bad register setting flags every item.
      if ((max_value <= min_value) && (s.err == ERR_NONE)) begin
         s.err = ERR_MANY;
      end
      active = (s.err == ERR_NONE) && !is_empty;

      if (active && is_digit) begin
         if (s.in_num) begin
            s.accum = (prod > {4'd0, ACCUM_SAT}) ? ACCUM_SAT : prod[8:0];
         end else if ((s.gstate == GS_NUMBER) || (s.gstate == GS_RANGE)) begin
            s.err = ERR_COMMA;
         end else begin
            s.in_num = 1'b1;
            s.accum = {5'd0, char_code[3:0]};
         end
      end

      // A number ends at a non-digit or at the final item; its checks come
      // before the grammar check of the character that ends it.
      do_finish = s.in_num && (s.err == ERR_NONE) && ((active && !is_digit) || is_final);
      if (do_finish) begin
         num = s.accum;
         s.in_num = 1'b0;
         s.accum = 9'd0;
         if ((num < {1'b0, min_value}) || (num > {1'b0, max_value})) begin
            s.err = ERR_RANGE;
         end else if (s.gstate == GS_COMMA) begin
            s.gstate = GS_NUMBER;
            s.range_begin = num[7:0];
            first = num[7:0];
            add = 8'd1;
         end else begin
            s.gstate = GS_RANGE;
            if (num[7:0] < s.range_begin) begin
               s.err = ERR_DESC;
            end else begin
               first = s.range_begin + 8'd1;
               add = num[7:0] - s.range_begin;
            end
         end
         // An equal-ended range adds nothing and reports no span.
         if ((s.err == ERR_NONE) && (add != 8'd0)) begin
            total = {1'b0, s.entries} + {1'b0, add};
            if (total > MAX_ENTRIES) begin
               s.err = ERR_MANY;
            end else begin
               s.entries = total[7:0];
               sv = 1'b1;
               sf = first;
               sl = num[7:0];
            end
         end
      end

      if (active && !is_digit && (s.err == ERR_NONE)) begin
         if (s.gstate == GS_HYPHEN) begin
            s.err = ERR_DIGIT;
         end else if (char_code == CHAR_COMMA) begin
            s.gstate = GS_COMMA;
         end else if (s.gstate == GS_RANGE) begin
            s.err = ERR_COMMA;
         end else if (s.gstate == GS_COMMA) begin
            s.err = ERR_DIGIT;
         end else if (char_code == CHAR_HYPHEN) begin
            s.gstate = GS_HYPHEN;
         end else begin
            s.err = ERR_CHAR;
         end
      end
   end

   always_comb begin
      res.error_flag  = (s.err != ERR_NONE);
      res.error_kind  = s.err;
      res.span_valid  = sv && !res.error_flag;
      res.span_first  = res.error_flag ? 8'd0 : sf;
      res.span_last   = res.error_flag ? 8'd0 : sl;
      res.entry_total = res.error_flag ? 8'd0 : s.entries;
      res.list_done   = is_final && !res.error_flag;
      st_next = is_final ? STATE_RESET : s;
   end

endmodule

// ----- src/number_range_list_parser_unit.sv -----
// Top level of the number range list parser: input register, step logic, result register.
//
//   channel  direction  contents
//   req_     in         tdata: char_code; tlast: is_final; tuser: is_empty
//   rsp_     out        tdata: span bounds and entry total; tuser: flags and error kind
//   csr_     in         write enable, register index, write data
//
// One character per cycle sustained while rsp_tready is high; each result is registered.
// The parse state updates in the same cycle as an item moves from the input register to
// the result register, so back-to-back characters see each other's effect.
// Synchronous reset clears the parse state and valid flags; min is set to 0, max to 255.
// With rsp_tready low the result holds, the input register takes one more item,
// and then req_tready drops.
module number_range_list_parser_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,
   input  logic       req_tuser,   // [0] is_empty
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [23:0] rsp_tdata,  // [7:0] span_first, [15:8] span_last, [23:16] entry_total
   output logic [5:0] rsp_tuser,   // [0] span_valid, [1] list_done, [2] error_flag,
                                   // [5:3] error_kind
   input  logic       csr_we,
   input  logic       csr_addr,
   input  logic [7:0] csr_wdata
);
   import nrlp_pkg::*;

   `include "number_range_list_parser_unit_assert.svh"

   localparam logic CSR_MIN = 1'b0;
   localparam logic CSR_MAX = 1'b1;

   logic [7:0]      min_ff, max_ff;
   logic            in_valid_ff;
   logic [7:0]      in_char_ff;
   logic            in_final_ff;
   logic            in_empty_ff;
   nrlp_state_type  st_ff, st_in;
   nrlp_result_type res_in, res_ff;
   logic            rsp_valid_ff;
   logic            out_load;
   logic            advance;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 8'd0;
         max_ff <= 8'd255;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MIN: min_ff <= csr_wdata;
            CSR_MAX: max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff  <= req_tdata;
         in_final_ff <= req_tlast;
         in_empty_ff <= req_tuser;
      end
   end

   nrlp_step u_step (
      .st        (st_ff),
      .char_code (in_char_ff),
      .is_final  (in_final_ff),
      .is_empty  (in_empty_ff),
      .min_value (min_ff),
      .max_value (max_ff),
      .st_next   (st_in),
      .res       (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            st_ff <= st_in;
         end
         if (out_load) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {res_ff.entry_total, res_ff.span_last, res_ff.span_first};
   assign rsp_tuser  = {res_ff.error_kind, res_ff.error_flag, res_ff.list_done,
                        res_ff.span_valid};

   `NRLP_ASSERT_NOW(a_err_masks_span, rsp_valid_ff && res_ff.error_flag,
      !res_ff.span_valid && (res_ff.entry_total == 8'd0) && !res_ff.list_done,
      "error result carries span or total")
   `NRLP_ASSERT_NOW(a_err_kind_flag, rsp_valid_ff,
      res_ff.error_flag == (res_ff.error_kind != ERR_NONE),
      "error flag disagrees with error kind")
   `NRLP_ASSERT_NEXT(a_final_clears, advance && in_final_ff,
      (st_ff.gstate == GS_COMMA) && !st_ff.in_num && (st_ff.entries == 8'd0)
      && (st_ff.err == ERR_NONE),
      "parse state not cleared after final character")
   `NRLP_ASSERT_NEXT(a_held_item_kept, in_valid_ff && !advance,
      in_valid_ff && $stable(in_char_ff) && $stable(in_final_ff),
      "stalled input register lost its item")

endmodule
